[rtl/potm_pkg.sv]
// Shared types, codes and helper functions of the price-time order matcher.
package potm_pkg;

  // Command actions
  localparam logic [1:0] ACT_NEW     = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Time in force
  localparam logic [1:0] TIF_GTC  = 2'd0;
  localparam logic [1:0] TIF_IOC  = 2'd1;
  localparam logic [1:0] TIF_FOK  = 2'd2;
  localparam logic [1:0] TIF_RSVD = 2'd3;

  // Event kinds
  localparam logic [2:0] EV_REJECT    = 3'd0;
  localparam logic [2:0] EV_ACCEPT    = 3'd1;
  localparam logic [2:0] EV_TRADE     = 3'd2;
  localparam logic [2:0] EV_ADDED     = 3'd3;
  localparam logic [2:0] EV_REDUCED   = 3'd4;
  localparam logic [2:0] EV_REMOVED   = 3'd5;
  localparam logic [2:0] EV_CANCELLED = 3'd6;
  localparam logic [2:0] EV_REPLACED  = 3'd7;

  // Reject reasons
  localparam logic [2:0] RS_INSTR     = 3'd0;
  localparam logic [2:0] RS_PRICE     = 3'd1;
  localparam logic [2:0] RS_QTY       = 3'd2;
  localparam logic [2:0] RS_DUP       = 3'd3;
  localparam logic [2:0] RS_LIQUIDITY = 3'd4;
  localparam logic [2:0] RS_UNKNOWN   = 3'd5;
  localparam logic [2:0] RS_REPLACE   = 3'd6;
  localparam logic [2:0] RS_FULL      = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        seq;
    logic [7:0]         instr;
    logic [31:0]        oid;
    logic [31:0]        cid;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        aleft;
    logic [31:0]        cleft;
    logic               side;
    logic [2:0]         reason;
    logic               last;
  } evt_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_EMIT_REJ,
    OP_EMIT_ACCEPT,
    OP_EMIT_TRADE,
    OP_EMIT_CONTRA,
    OP_EMIT_FULL,
    OP_EMIT_ADDED,
    OP_EMIT_CANCEL,
    OP_EMIT_CANCEL_RM,
    OP_EMIT_REPL_KEEP,
    OP_EMIT_REPL_RED,
    OP_EMIT_REPL_NEW,
    OP_EMIT_REPL_RM,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [2:0] {
    SC_KEY,
    SC_NKEY,
    SC_AVAIL,
    SC_BEST,
    SC_FREE
  } scan_e;

  typedef struct packed {
    dp_op_e     op;
    scan_e      scan;
    logic [2:0] reason;
    logic       in_ready;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] action;
    logic [1:0] tif;
    logic       known;
    logic       price_bad;
    logic       qty_zero;
    logic       key_found;
    logic       instr_match;
    logic       keys_differ;
    logic       dup_found;
    logic       avail_short;
    logic       best_found;
    logic       crosses;
    logic       rem_zero;
    logic       repl_keep;
    logic       free_found;
    logic       scan_last;
    logic       can_push;
  } dp_stat_t;

  // Buy crosses at or above the contra price, sell at or below.
  function automatic logic crosses(input logic side, input logic signed [31:0] price,
                                   input logic signed [31:0] cprice);
    crosses = side ? (price <= cprice) : (price >= cprice);
  endfunction

  // Serial-number compare: a was issued before b.
  function automatic logic older(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff  = a - b;
    older = diff[31];
  endfunction

endpackage

[rtl/potm_if.sv]
// Valid/ready channel interfaces for commands and events.
interface potm_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         instrument;
  logic [15:0]        account;
  logic [31:0]        client_id;
  logic [31:0]        new_client_id;
  logic               side;
  logic signed [31:0] limit_price;
  logic [31:0]        order_qty;
  logic [1:0]         tif;

  modport source(output valid, action, instrument, account, client_id, new_client_id, side,
                 limit_price, order_qty, tif, input ready);
  modport sink(input valid, action, instrument, account, client_id, new_client_id, side,
               limit_price, order_qty, tif, output ready);
endinterface

interface potm_evt_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [31:0]        event_seq;
  logic [7:0]         instrument_out;
  logic [31:0]        order_id;
  logic [31:0]        contra_id;
  logic signed [31:0] event_price;
  logic [31:0]        event_qty;
  logic [31:0]        aggressor_left;
  logic [31:0]        contra_left;
  logic               event_side;
  logic [2:0]         reject_reason;
  logic               last;

  modport source(output valid, event_kind, event_seq, instrument_out, order_id, contra_id,
                 event_price, event_qty, aggressor_left, contra_left, event_side,
                 reject_reason, last, input ready);
  modport sink(input valid, event_kind, event_seq, instrument_out, order_id, contra_id,
               event_price, event_qty, aggressor_left, contra_left, event_side,
               reject_reason, last, output ready);
endinterface

[rtl/potm_ctrl.sv]
// Command sequencer of the order matcher.
module potm_ctrl
  import potm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_SCAN   = 5'd2;
  localparam logic [4:0] S_REJ    = 5'd3;
  localparam logic [4:0] S_FIN    = 5'd4;
  localparam logic [4:0] S_K_NEW  = 5'd5;
  localparam logic [4:0] S_A_NEW  = 5'd6;
  localparam logic [4:0] S_ACCEPT = 5'd7;
  localparam logic [4:0] S_MATCH  = 5'd8;
  localparam logic [4:0] S_B_DONE = 5'd9;
  localparam logic [4:0] S_TRADE  = 5'd10;
  localparam logic [4:0] S_CONTRA = 5'd11;
  localparam logic [4:0] S_REST   = 5'd12;
  localparam logic [4:0] S_F_DONE = 5'd13;
  localparam logic [4:0] S_K_CAN  = 5'd14;
  localparam logic [4:0] S_CAN1   = 5'd15;
  localparam logic [4:0] S_CAN2   = 5'd16;
  localparam logic [4:0] S_K_REP  = 5'd17;
  localparam logic [4:0] S_N_REP  = 5'd18;
  localparam logic [4:0] S_REP    = 5'd19;
  localparam logic [4:0] S_RK1    = 5'd20;
  localparam logic [4:0] S_RK2    = 5'd21;
  localparam logic [4:0] S_RN1    = 5'd22;
  localparam logic [4:0] S_RN2    = 5'd23;

  logic [4:0] state_q, state_d;
  logic [4:0] ret_q, ret_d;
  logic [2:0] reason_q, reason_d;

  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    reason_d        = reason_q;
    cmd_o.op        = OP_NONE;
    cmd_o.scan      = SC_KEY;
    cmd_o.reason    = reason_q;
    cmd_o.in_ready  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.action == ACT_NONE) begin
          state_d = S_IDLE;
        end else if (!stat_i.known) begin
          reason_d = RS_INSTR;
          state_d  = S_REJ;
        end else if (stat_i.action == ACT_NEW) begin
          if (stat_i.price_bad) begin
            reason_d = RS_PRICE;
            state_d  = S_REJ;
          end else if (stat_i.qty_zero) begin
            reason_d = RS_QTY;
            state_d  = S_REJ;
          end else begin
            cmd_o.op = OP_SCAN_INIT;
            state_d  = S_SCAN;
            ret_d    = S_K_NEW;
          end
        end else if (stat_i.action == ACT_CANCEL) begin
          cmd_o.op = OP_SCAN_INIT;
          state_d  = S_SCAN;
          ret_d    = S_K_CAN;
        end else if (stat_i.price_bad || stat_i.qty_zero) begin
          reason_d = RS_REPLACE;
          state_d  = S_REJ;
        end else begin
          cmd_o.op = OP_SCAN_INIT;
          state_d  = S_SCAN;
          ret_d    = S_K_REP;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN_STEP;
        if (stat_i.scan_last) begin
          state_d = ret_q;
        end
      end
      S_REJ: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_REJ;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      S_K_NEW: begin
        if (stat_i.key_found) begin
          reason_d = RS_DUP;
          state_d  = S_REJ;
        end else if (stat_i.tif == TIF_FOK) begin
          cmd_o.op   = OP_SCAN_INIT;
          cmd_o.scan = SC_AVAIL;
          state_d    = S_SCAN;
          ret_d      = S_A_NEW;
        end else begin
          state_d = S_ACCEPT;
        end
      end
      S_A_NEW: begin
        if (stat_i.avail_short) begin
          reason_d = RS_LIQUIDITY;
          state_d  = S_REJ;
        end else begin
          state_d = S_ACCEPT;
        end
      end
      S_ACCEPT: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_ACCEPT;
          state_d  = S_MATCH;
        end
      end
      S_MATCH: begin
        if (stat_i.rem_zero) begin
          state_d = S_REST;
        end else begin
          cmd_o.op   = OP_SCAN_INIT;
          cmd_o.scan = SC_BEST;
          state_d    = S_SCAN;
          ret_d      = S_B_DONE;
        end
      end
      S_B_DONE: begin
        if (stat_i.best_found && stat_i.crosses) begin
          state_d = S_TRADE;
        end else begin
          state_d = S_REST;
        end
      end
      S_TRADE: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_TRADE;
          state_d  = S_CONTRA;
        end
      end
      S_CONTRA: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_CONTRA;
          state_d  = S_MATCH;
        end
      end
      S_REST: begin
        if (stat_i.tif != TIF_GTC || stat_i.rem_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op   = OP_SCAN_INIT;
          cmd_o.scan = SC_FREE;
          state_d    = S_SCAN;
          ret_d      = S_F_DONE;
        end
      end
      S_F_DONE: begin
        if (stat_i.can_push) begin
          cmd_o.op = stat_i.free_found ? OP_EMIT_ADDED : OP_EMIT_FULL;
          state_d  = S_FIN;
        end
      end
      S_K_CAN: begin
        if (!stat_i.key_found || !stat_i.instr_match) begin
          reason_d = RS_UNKNOWN;
          state_d  = S_REJ;
        end else begin
          state_d = S_CAN1;
        end
      end
      S_CAN1: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_CANCEL;
          state_d  = S_CAN2;
        end
      end
      S_CAN2: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_CANCEL_RM;
          state_d  = S_FIN;
        end
      end
      S_K_REP: begin
        if (!stat_i.key_found || !stat_i.instr_match) begin
          reason_d = RS_UNKNOWN;
          state_d  = S_REJ;
        end else if (stat_i.keys_differ) begin
          cmd_o.op   = OP_SCAN_INIT;
          cmd_o.scan = SC_NKEY;
          state_d    = S_SCAN;
          ret_d      = S_N_REP;
        end else begin
          state_d = S_REP;
        end
      end
      S_N_REP: begin
        if (stat_i.dup_found) begin
          reason_d = RS_DUP;
          state_d  = S_REJ;
        end else begin
          state_d = S_REP;
        end
      end
      S_REP: begin
        state_d = stat_i.repl_keep ? S_RK1 : S_RN1;
      end
      S_RK1: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_REPL_KEEP;
          state_d  = S_RK2;
        end
      end
      S_RK2: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_REPL_RED;
          state_d  = S_FIN;
        end
      end
      S_RN1: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_REPL_NEW;
          state_d  = S_RN2;
        end
      end
      S_RN2: begin
        if (stat_i.can_push) begin
          cmd_o.op = OP_EMIT_REPL_RM;
          state_d  = S_MATCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      reason_q <= RS_INSTR;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      reason_q <= reason_d;
    end
  end

endmodule

[rtl/potm_dp.sv]
// Datapath of the order matcher: order store, scan unit, counters and event buffers.
module potm_dp
  import potm_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS      = 16,
  parameter int unsigned INSTRUMENT_SLOTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_stat_t   stat_o,
  potm_cmd_if.sink   in_i,
  potm_evt_if.source evt_o
);

  localparam int unsigned IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned AW = 32 + $clog2(ORDER_SLOTS + 1);

  // Configuration and latched command
  logic [3:0]         en_q;
  logic [1:0]         action_q;
  logic [7:0]         instr_q;
  logic [15:0]        acct_q;
  logic [31:0]        cid_q, ncid_q;
  logic               side_q;
  logic signed [31:0] price_q;
  logic [31:0]        qty_q;
  logic [1:0]         tif_q;
  logic [47:0]        rest_key_q;

  // Order store; attributes are {instr[1:0], tif[1:0], side}
  logic               valid_q  [ORDER_SLOTS];
  logic [47:0]        key_q    [ORDER_SLOTS];
  logic signed [31:0] sprice_q [ORDER_SLOTS];
  logic [31:0]        srem_q   [ORDER_SLOTS];
  logic [31:0]        sid_q    [ORDER_SLOTS];
  logic [31:0]        sprio_q  [ORDER_SLOTS];
  logic [4:0]         sattr_q  [ORDER_SLOTS];

  // Scan unit
  logic [IW-1:0]      idx_q;
  scan_e              scan_q;
  logic               f_found_q;
  logic [IW-1:0]      f_idx_q;
  logic signed [31:0] f_price_q;
  logic [31:0]        f_rem_q, f_id_q;
  logic [4:0]         f_attr_q;
  logic               dup_q;
  logic [AW-1:0]      avail_q;
  logic               b_found_q;
  logic [IW-1:0]      b_idx_q;
  logic signed [31:0] b_price_q;
  logic [31:0]        b_prio_q, b_rem_q, b_id_q;
  logic               free_found_q;
  logic [IW-1:0]      free_idx_q;

  // Working order and counters
  logic [31:0]        rem_q, oid_q, prio_q, cl_q;
  logic [31:0]        ev_cnt_q, xid_cnt_q, prio_cnt_q;

  // Pending event and output register
  logic               pend_v_q, out_v_q;
  evt_t               pend_q, out_q, out_d;

  // Current slot under the scan pointer
  logic               cur_v;
  logic [47:0]        cur_key;
  logic signed [31:0] cur_price;
  logic [31:0]        cur_rem, cur_id, cur_prio;
  logic [4:0]         cur_attr;
  logic               cur_instr_ok;
  logic               hit_key, hit_nkey, hit_avail, hit_best, hit_free;

  logic [47:0]        ckey, nkey;
  logic [31:0]        tq, rem_n, cl_n;
  logic               is_emit, push, fin, load_out, out_fire, out_free, can_push;
  evt_t               ev;

  assign ckey = {acct_q, cid_q};
  assign nkey = {acct_q, ncid_q};

  assign cur_v     = valid_q[idx_q];
  assign cur_key   = key_q[idx_q];
  assign cur_price = sprice_q[idx_q];
  assign cur_rem   = srem_q[idx_q];
  assign cur_id    = sid_q[idx_q];
  assign cur_prio  = sprio_q[idx_q];
  assign cur_attr  = sattr_q[idx_q];
  assign cur_instr_ok = cur_attr[4:3] == instr_q[1:0];

  always_comb begin
    hit_key   = cur_v && (cur_key == ckey) && !f_found_q;
    hit_nkey  = cur_v && (cur_key == nkey);
    hit_avail = cur_v && cur_instr_ok && (cur_attr[0] != side_q) &&
                crosses(side_q, price_q, cur_price);
    hit_free  = !cur_v && !free_found_q;
    hit_best  = 1'b0;
    if (cur_v && cur_instr_ok && (cur_attr[0] == !side_q)) begin
      if (!b_found_q) begin
        hit_best = 1'b1;
      end else if (!side_q ? (cur_price < b_price_q) : (cur_price > b_price_q)) begin
        hit_best = 1'b1;
      end else if (cur_price == b_price_q && older(cur_prio, b_prio_q)) begin
        hit_best = 1'b1;
      end
    end
  end

  // Trade size against the best contra order
  assign tq    = (rem_q < b_rem_q) ? rem_q : b_rem_q;
  assign rem_n = rem_q - tq;
  assign cl_n  = b_rem_q - tq;

  assign out_fire = out_v_q && evt_o.ready;
  assign out_free = !out_v_q || evt_o.ready;
  assign can_push = !pend_v_q || out_free;

  always_comb begin
    is_emit = cmd_i.op inside {OP_EMIT_REJ, OP_EMIT_ACCEPT, OP_EMIT_TRADE, OP_EMIT_CONTRA,
                               OP_EMIT_FULL, OP_EMIT_ADDED, OP_EMIT_CANCEL,
                               OP_EMIT_CANCEL_RM, OP_EMIT_REPL_KEEP, OP_EMIT_REPL_RED,
                               OP_EMIT_REPL_NEW, OP_EMIT_REPL_RM};
  end
  assign push     = is_emit && can_push;
  assign fin      = (cmd_i.op == OP_FINISH) && pend_v_q && out_free;
  assign load_out = (push && pend_v_q) || fin;

  // Mark the pending beat as the command's last when it leaves on a finish
  always_comb begin
    out_d      = pend_q;
    out_d.last = fin;
  end

  // Build the event of the current emit command
  always_comb begin
    ev       = '0;
    ev.seq   = ev_cnt_q;
    ev.instr = instr_q;
    case (cmd_i.op)
      OP_EMIT_REJ: begin
        ev.kind   = EV_REJECT;
        ev.reason = cmd_i.reason;
      end
      OP_EMIT_ACCEPT: begin
        ev.kind  = EV_ACCEPT;
        ev.oid   = xid_cnt_q;
        ev.price = price_q;
        ev.qty   = qty_q;
        ev.side  = side_q;
      end
      OP_EMIT_TRADE: begin
        ev.kind  = EV_TRADE;
        ev.oid   = oid_q;
        ev.cid   = b_id_q;
        ev.price = b_price_q;
        ev.qty   = tq;
        ev.aleft = rem_n;
        ev.cleft = cl_n;
        ev.side  = side_q;
      end
      OP_EMIT_CONTRA: begin
        ev.kind  = (cl_q == '0) ? EV_REMOVED : EV_REDUCED;
        ev.oid   = b_id_q;
        ev.price = b_price_q;
        ev.qty   = cl_q;
        ev.side  = !side_q;
      end
      OP_EMIT_FULL: begin
        ev.kind   = EV_REJECT;
        ev.oid    = oid_q;
        ev.qty    = rem_q;
        ev.side   = side_q;
        ev.reason = RS_FULL;
      end
      OP_EMIT_ADDED: begin
        ev.kind  = EV_ADDED;
        ev.oid   = oid_q;
        ev.price = price_q;
        ev.qty   = rem_q;
        ev.side  = side_q;
      end
      OP_EMIT_CANCEL: begin
        ev.kind = EV_CANCELLED;
        ev.oid  = f_id_q;
        ev.side = f_attr_q[0];
      end
      OP_EMIT_CANCEL_RM, OP_EMIT_REPL_RM: begin
        ev.kind  = EV_REMOVED;
        ev.oid   = f_id_q;
        ev.price = f_price_q;
        ev.side  = f_attr_q[0];
      end
      OP_EMIT_REPL_KEEP: begin
        ev.kind  = EV_REPLACED;
        ev.oid   = f_id_q;
        ev.price = price_q;
        ev.qty   = qty_q;
        ev.side  = f_attr_q[0];
      end
      OP_EMIT_REPL_RED: begin
        ev.kind  = EV_REDUCED;
        ev.oid   = f_id_q;
        ev.price = f_price_q;
        ev.qty   = qty_q;
        ev.side  = f_attr_q[0];
      end
      OP_EMIT_REPL_NEW: begin
        ev.kind  = EV_REPLACED;
        ev.oid   = xid_cnt_q;
        ev.price = price_q;
        ev.qty   = qty_q;
        ev.side  = f_attr_q[0];
      end
      default: begin
        ev.kind = EV_REJECT;
      end
    endcase
  end

  // Control state: config, valid bits, counters, scan pointer and flags, buffers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= '0;
      for (int i = 0; i < ORDER_SLOTS; i++) begin
        valid_q[i] <= 1'b0;
      end
      ev_cnt_q     <= '0;
      xid_cnt_q    <= '0;
      prio_cnt_q   <= '0;
      idx_q        <= '0;
      scan_q       <= SC_KEY;
      f_found_q    <= 1'b0;
      dup_q        <= 1'b0;
      b_found_q    <= 1'b0;
      free_found_q <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_SCAN_INIT: begin
          idx_q  <= '0;
          scan_q <= cmd_i.scan;
          case (cmd_i.scan)
            SC_KEY:  f_found_q    <= 1'b0;
            SC_NKEY: dup_q        <= 1'b0;
            SC_BEST: b_found_q    <= 1'b0;
            SC_FREE: free_found_q <= 1'b0;
            default: ;
          endcase
        end
        OP_SCAN_STEP: begin
          idx_q <= (idx_q == IW'(ORDER_SLOTS - 1)) ? '0 : idx_q + 1'b1;
          case (scan_q)
            SC_KEY:  if (hit_key)  f_found_q    <= 1'b1;
            SC_NKEY: if (hit_nkey) dup_q        <= 1'b1;
            SC_BEST: if (hit_best) b_found_q    <= 1'b1;
            SC_FREE: if (hit_free) free_found_q <= 1'b1;
            default: ;
          endcase
        end
        OP_EMIT_ACCEPT: begin
          if (push) begin
            xid_cnt_q  <= xid_cnt_q + 1'b1;
            prio_cnt_q <= prio_cnt_q + 1'b1;
          end
        end
        OP_EMIT_REPL_NEW: begin
          if (push) begin
            xid_cnt_q        <= xid_cnt_q + 1'b1;
            valid_q[f_idx_q] <= 1'b0;
          end
        end
        OP_EMIT_REPL_RM: begin
          if (push) prio_cnt_q <= prio_cnt_q + 1'b1;
        end
        OP_EMIT_CONTRA: begin
          if (push && cl_q == '0) valid_q[b_idx_q] <= 1'b0;
        end
        OP_EMIT_ADDED: begin
          if (push) valid_q[free_idx_q] <= 1'b1;
        end
        OP_EMIT_CANCEL: begin
          if (push) valid_q[f_idx_q] <= 1'b0;
        end
        default: ;
      endcase
      if (push) begin
        ev_cnt_q <= ev_cnt_q + 1'b1;
        pend_v_q <= 1'b1;
      end else if (fin) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_fire) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload: command latch, slot contents, captured scan results, event buffers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        action_q   <= in_i.action;
        instr_q    <= in_i.instrument;
        acct_q     <= in_i.account;
        cid_q      <= in_i.client_id;
        ncid_q     <= in_i.new_client_id;
        side_q     <= in_i.side;
        price_q    <= in_i.limit_price;
        qty_q      <= in_i.order_qty;
        tif_q      <= (in_i.tif == TIF_RSVD) ? TIF_IOC : in_i.tif;
        rest_key_q <= {in_i.account, in_i.client_id};
      end
      OP_SCAN_INIT: begin
        if (cmd_i.scan == SC_AVAIL) avail_q <= '0;
      end
      OP_SCAN_STEP: begin
        case (scan_q)
          SC_KEY: begin
            if (hit_key) begin
              f_idx_q   <= idx_q;
              f_price_q <= cur_price;
              f_rem_q   <= cur_rem;
              f_id_q    <= cur_id;
              f_attr_q  <= cur_attr;
            end
          end
          SC_AVAIL: begin
            if (hit_avail) avail_q <= avail_q + AW'(cur_rem);
          end
          SC_BEST: begin
            if (hit_best) begin
              b_idx_q   <= idx_q;
              b_price_q <= cur_price;
              b_prio_q  <= cur_prio;
              b_rem_q   <= cur_rem;
              b_id_q    <= cur_id;
            end
          end
          SC_FREE: begin
            if (hit_free) free_idx_q <= idx_q;
          end
          default: ;
        endcase
      end
      OP_EMIT_ACCEPT: begin
        if (push) begin
          oid_q  <= xid_cnt_q;
          prio_q <= prio_cnt_q;
          rem_q  <= qty_q;
        end
      end
      OP_EMIT_TRADE: begin
        if (push) begin
          rem_q <= rem_n;
          cl_q  <= cl_n;
        end
      end
      OP_EMIT_CONTRA: begin
        if (push && cl_q != '0) srem_q[b_idx_q] <= cl_q;
      end
      OP_EMIT_ADDED: begin
        if (push) begin
          key_q[free_idx_q]    <= rest_key_q;
          sprice_q[free_idx_q] <= price_q;
          srem_q[free_idx_q]   <= rem_q;
          sid_q[free_idx_q]    <= oid_q;
          sprio_q[free_idx_q]  <= prio_q;
          sattr_q[free_idx_q]  <= {instr_q[1:0], tif_q, side_q};
        end
      end
      OP_EMIT_REPL_KEEP: begin
        if (push) begin
          srem_q[f_idx_q] <= qty_q;
          key_q[f_idx_q]  <= nkey;
        end
      end
      OP_EMIT_REPL_NEW: begin
        if (push) begin
          oid_q      <= xid_cnt_q;
          side_q     <= f_attr_q[0];
          tif_q      <= f_attr_q[2:1];
          rest_key_q <= nkey;
        end
      end
      OP_EMIT_REPL_RM: begin
        if (push) begin
          prio_q <= prio_cnt_q;
          rem_q  <= qty_q;
        end
      end
      default: ;
    endcase
    if (push) begin
      pend_q <= ev;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Status to the sequencer
  always_comb begin
    stat_o.in_valid    = in_i.valid;
    stat_o.action      = action_q;
    stat_o.tif         = tif_q;
    stat_o.known       = (instr_q < 8'(INSTRUMENT_SLOTS)) && en_q[instr_q[1:0]];
    stat_o.price_bad   = price_q[31] || (price_q == '0);
    stat_o.qty_zero    = qty_q == '0;
    stat_o.key_found   = f_found_q;
    stat_o.instr_match = f_attr_q[4:3] == instr_q[1:0];
    stat_o.keys_differ = cid_q != ncid_q;
    stat_o.dup_found   = dup_q;
    stat_o.avail_short = avail_q < {{(AW - 32){1'b0}}, qty_q};
    stat_o.best_found  = b_found_q;
    stat_o.crosses     = crosses(side_q, price_q, b_price_q);
    stat_o.rem_zero    = rem_q == '0;
    stat_o.repl_keep   = (price_q == f_price_q) && (qty_q <= f_rem_q);
    stat_o.free_found  = free_found_q;
    stat_o.scan_last   = idx_q == IW'(ORDER_SLOTS - 1);
    stat_o.can_push    = can_push;
  end

  assign in_i.ready           = cmd_i.in_ready;
  assign evt_o.valid          = out_v_q;
  assign evt_o.event_kind     = out_q.kind;
  assign evt_o.event_seq      = out_q.seq;
  assign evt_o.instrument_out = out_q.instr;
  assign evt_o.order_id       = out_q.oid;
  assign evt_o.contra_id      = out_q.cid;
  assign evt_o.event_price    = out_q.price;
  assign evt_o.event_qty      = out_q.qty;
  assign evt_o.aggressor_left = out_q.aleft;
  assign evt_o.contra_left    = out_q.cleft;
  assign evt_o.event_side     = out_q.side;
  assign evt_o.reject_reason  = out_q.reason;
  assign evt_o.last           = out_q.last;

  // The sequencer issues an emit only when the pending beat can move on.
  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_emit |-> can_push)
    else $error("emit issued with pending and output beats both occupied");

  // The sequence number advances only when an event is pushed.
  a_seq_only_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push |=> $stable(ev_cnt_q))
    else $error("event sequence moved without an event");

  // A finish never runs while the output still holds an untaken beat.
  a_fin_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FINISH) && pend_v_q |-> fin || (out_v_q && !evt_o.ready))
    else $error("finish dropped the last event");

endmodule

[rtl/price_time_order_matcher_unit.sv]
// Top level of the price-time priority order matcher.
//
// Limit order book with price-time priority for up to INSTRUMENT_SLOTS instruments that
// share one store of ORDER_SLOTS resting orders. Each accepted command beat (new, cancel,
// replace) yields a burst of event beats: reject, or accept followed by trade and
// reduced/removed pairs and an added (or full reject) for a GTC remainder; cancel and
// replace give their own pairs. The final beat of a command carries last. Commands are
// processed one at a time. Every key lookup, FOK liquidity sum, best-contra search and
// free-slot search walks the store one slot per cycle through a single scan pointer; an
// emit waits while the event output and its pending beat are both full. The event
// output is registered with one further pending beat, so the sequencer keeps working
// while a finished beat waits for the consumer. instrument_enable is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while no command is in flight, as the
// block itself does not enforce it. Bits at or above INSTRUMENT_SLOTS are ignored.
// Reset empties the book and clears all counters.
module price_time_order_matcher_unit
  import potm_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS      = 16,
  parameter int unsigned INSTRUMENT_SLOTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  potm_cmd_if.sink   cmd_i,
  potm_evt_if.source evt_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequencer: walks each command through its searches and emits
  potm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (dp_stat),
    .cmd_o  (ctrl_cmd)
  );

  // Datapath: order store, scan unit, counters and event buffering
  potm_dp #(
    .ORDER_SLOTS      (ORDER_SLOTS),
    .INSTRUMENT_SLOTS (INSTRUMENT_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .in_i        (cmd_i),
    .evt_o       (evt_o)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the price-time order matcher: directed and random commands.
module tb
  import potm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BOOK_SLOTS  = 16;
  localparam int unsigned INSTR_SLOTS = 4;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 200;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         instrument;
    logic [15:0]        account;
    logic [31:0]        client_id;
    logic [31:0]        new_client_id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [1:0]         tif;
  } order_cmd_t;

  // Book mirror plus the queue of event beats still owed by the DUT.
  class book_scoreboard;
    logic [3:0]         enable;
    bit                 live[BOOK_SLOTS];
    logic [47:0]        okey[BOOK_SLOTS];
    logic signed [31:0] opx[BOOK_SLOTS];
    logic [31:0]        oleft[BOOK_SLOTS];
    logic [31:0]        oxid[BOOK_SLOTS];
    logic [31:0]        oprio[BOOK_SLOTS];
    logic               oside[BOOK_SLOTS];
    logic [1:0]         otif[BOOK_SLOTS];
    logic [1:0]         oinstr[BOOK_SLOTS];
    logic [31:0]        seq_ctr, xid_ctr, prio_ctr;
    logic [7:0]         cur_instr;
    evt_t               owed[$];
    evt_t               burst[$];
    int                 errors, checked, commands;

    function new();
      enable = '0; seq_ctr = '0; xid_ctr = '0; prio_ctr = '0;
      errors = 0; checked = 0; commands = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [31:0] oid, logic [31:0] cid,
                       logic signed [31:0] px, logic [31:0] qty, logic [31:0] aleft,
                       logic [31:0] cleft, logic sd, logic [2:0] reason);
      evt_t e;
      e.kind = kind; e.seq = seq_ctr; e.instr = cur_instr; e.oid = oid; e.cid = cid;
      e.price = px; e.qty = qty; e.aleft = aleft; e.cleft = cleft; e.side = sd;
      e.reason = reason; e.last = 1'b0;
      seq_ctr++;
      burst = {burst, e};
    endfunction

    function int find_key(logic [47:0] k);
      for (int i = 0; i < BOOK_SLOTS; i++)
        if (live[i] && okey[i] == k) return i;
      return -1;
    endfunction

    function bit is_older(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function bit does_cross(logic sd, logic signed [31:0] px, logic signed [31:0] cpx);
      return sd ? (px <= cpx) : (px >= cpx);
    endfunction

    function int best_resting(logic [1:0] ins, logic cside);
      int best;
      best = -1;
      for (int i = 0; i < BOOK_SLOTS; i++) begin
        if (!live[i] || oinstr[i] != ins || oside[i] != cside) continue;
        if (best < 0) best = i;
        else if (cside ? opx[i] < opx[best] : opx[i] > opx[best]) best = i;
        else if (opx[i] == opx[best] && is_older(oprio[i], oprio[best])) best = i;
      end
      return best;
    endfunction

    // Sweep the contra side while the incoming order still crosses.
    function void sweep(logic [1:0] ins, logic sd, logic signed [31:0] px,
                        ref logic [31:0] left, input logic [31:0] oid);
      int b;
      logic [31:0] tq, cl;
      while (left > 0) begin
        b = best_resting(ins, ~sd);
        if (b < 0 || !does_cross(sd, px, opx[b])) break;
        tq = (left < oleft[b]) ? left : oleft[b];
        left -= tq;
        cl = oleft[b] - tq;
        emit(EV_TRADE, oid, oxid[b], opx[b], tq, left, cl, sd, '0);
        if (cl == 0) begin
          live[b] = 0;
          emit(EV_REMOVED, oxid[b], '0, opx[b], '0, '0, '0, ~sd, '0);
        end else begin
          oleft[b] = cl;
          emit(EV_REDUCED, oxid[b], '0, opx[b], cl, '0, '0, ~sd, '0);
        end
      end
    endfunction

    function void rest_remainder(logic [47:0] k, logic [1:0] ins, logic sd, logic [1:0] tf,
                                 logic signed [31:0] px, logic [31:0] left,
                                 logic [31:0] oid, logic [31:0] pr);
      int f;
      f = -1;
      if (tf != TIF_GTC || left == 0) return;
      for (int i = BOOK_SLOTS - 1; i >= 0; i--)
        if (!live[i]) f = i;
      if (f < 0) begin
        emit(EV_REJECT, oid, '0, '0, left, '0, '0, sd, RS_FULL);
        return;
      end
      live[f] = 1; okey[f] = k; opx[f] = px; oleft[f] = left; oxid[f] = oid;
      oprio[f] = pr; oside[f] = sd; otif[f] = tf; oinstr[f] = ins;
      emit(EV_ADDED, oid, '0, px, left, '0, '0, sd, '0);
    endfunction

    function void note_command(order_cmd_t c);
      logic [47:0] k, nk;
      logic [1:0]  tf, ins;
      logic [31:0] oid, pr, left;
      logic [63:0] avail;
      int          s;
      commands++;
      if (c.action == ACT_NONE) return;
      tf = (c.tif == TIF_RSVD) ? TIF_IOC : c.tif;
      ins = c.instrument[1:0];
      k = {c.account, c.client_id};
      nk = {c.account, c.new_client_id};
      cur_instr = c.instrument;
      burst.delete();
      if (!(c.instrument < INSTR_SLOTS && enable[ins])) begin
        emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_INSTR);
      end else if (c.action == ACT_NEW) begin
        if (c.price <= 0) emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_PRICE);
        else if (c.qty == 0) emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_QTY);
        else if (find_key(k) >= 0) emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_DUP);
        else begin
          avail = '0;
          if (tf == TIF_FOK)
            for (int i = 0; i < BOOK_SLOTS; i++)
              if (live[i] && oinstr[i] == ins && oside[i] != c.side &&
                  does_cross(c.side, c.price, opx[i]))
                avail += oleft[i];
          if (tf == TIF_FOK && avail < c.qty) begin
            emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_LIQUIDITY);
          end else begin
            oid = xid_ctr++;
            pr = prio_ctr++;
            emit(EV_ACCEPT, oid, '0, c.price, c.qty, '0, '0, c.side, '0);
            left = c.qty;
            sweep(ins, c.side, c.price, left, oid);
            rest_remainder(k, ins, c.side, tf, c.price, left, oid, pr);
          end
        end
      end else if (c.action == ACT_CANCEL) begin
        s = find_key(k);
        if (s < 0 || oinstr[s] != ins) begin
          emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_UNKNOWN);
        end else begin
          live[s] = 0;
          emit(EV_CANCELLED, oxid[s], '0, '0, '0, '0, '0, oside[s], '0);
          emit(EV_REMOVED, oxid[s], '0, opx[s], '0, '0, '0, oside[s], '0);
        end
      end else begin
        s = find_key(k);
        if (c.price <= 0 || c.qty == 0)
          emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_REPLACE);
        else if (s < 0 || oinstr[s] != ins)
          emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_UNKNOWN);
        else if (nk != k && find_key(nk) >= 0)
          emit(EV_REJECT, '0, '0, '0, '0, '0, '0, 1'b0, RS_DUP);
        else if (c.price == opx[s] && c.qty <= oleft[s]) begin
          // Same price, no growth: keep queue position.
          oleft[s] = c.qty;
          okey[s] = nk;
          emit(EV_REPLACED, oxid[s], '0, c.price, c.qty, '0, '0, oside[s], '0);
          emit(EV_REDUCED, oxid[s], '0, opx[s], c.qty, '0, '0, oside[s], '0);
        end else begin
          live[s] = 0;
          oid = xid_ctr++;
          emit(EV_REPLACED, oid, '0, c.price, c.qty, '0, '0, oside[s], '0);
          emit(EV_REMOVED, oxid[s], '0, opx[s], '0, '0, '0, oside[s], '0);
          pr = prio_ctr++;
          left = c.qty;
          sweep(ins, oside[s], c.price, left, oid);
          rest_remainder(nk, ins, oside[s], otif[s], c.price, left, oid, pr);
        end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      owed = {owed, burst};
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] got_v, ref bit bad);
      if (exp_v !== got_v) begin
        $display("%0t: event %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        bad = 1;
      end
    endfunction

    function void check_event(evt_t got);
      evt_t e;
      bit bad;
      bad = 0;
      checked++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected event beat, actual %p", $time, got);
        errors++;
        return;
      end
      e = owed.pop_front();
      field("kind", e.kind, got.kind, bad);
      field("seq", e.seq, got.seq, bad);
      field("instrument", e.instr, got.instr, bad);
      field("order_id", e.oid, got.oid, bad);
      field("contra_id", e.cid, got.cid, bad);
      field("price", e.price, got.price, bad);
      field("qty", e.qty, got.qty, bad);
      field("aggressor_left", e.aleft, got.aleft, bad);
      field("contra_left", e.cleft, got.cleft, bad);
      field("side", e.side, got.side, bad);
      field("reason", e.reason, got.reason, bad);
      field("last", e.last, got.last, bad);
      if (bad) errors++;
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  potm_cmd_if cmd_bus();
  potm_evt_if evt_bus();

  book_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    hold_left = 0;
  int unsigned    settings = 0;
  int unsigned    burst_left = 0;

  price_time_order_matcher_unit #(
    .ORDER_SLOTS     (BOOK_SLOTS),
    .INSTRUMENT_SLOTS(INSTR_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .cmd_i      (cmd_bus),
    .evt_o      (evt_bus)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hang ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, sb.owed.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Event receiver: a long hold-off when asked, otherwise short random stalls.
  initial begin
    int unsigned stall_run;
    stall_run = 0;
    evt_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        evt_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_run > 0) begin
        evt_bus.ready <= 1'b0;
        stall_run--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_run = $urandom_range(0, 6);
        evt_bus.ready <= 1'b0;
      end else begin
        evt_bus.ready <= 1'b1;
      end
    end
  end

  // Sample each accepted event beat at the rising edge.
  always @(posedge clk_i) begin
    evt_t got;
    if (rst_ni && evt_bus.valid && evt_bus.ready) begin
      got.kind = evt_bus.event_kind;     got.seq = evt_bus.event_seq;
      got.instr = evt_bus.instrument_out; got.oid = evt_bus.order_id;
      got.cid = evt_bus.contra_id;       got.price = evt_bus.event_price;
      got.qty = evt_bus.event_qty;       got.aleft = evt_bus.aggressor_left;
      got.cleft = evt_bus.contra_left;   got.side = evt_bus.event_side;
      got.reason = evt_bus.reject_reason; got.last = evt_bus.last;
      sb.check_event(got);
    end
  end

  function automatic order_cmd_t mk(logic [1:0] act, logic [7:0] ins, logic [15:0] acct,
                                    logic [31:0] cid, logic [31:0] ncid, logic sd,
                                    logic signed [31:0] px, logic [31:0] qty, logic [1:0] tf);
    order_cmd_t c;
    c.action = act; c.instrument = ins; c.account = acct; c.client_id = cid;
    c.new_client_id = ncid; c.side = sd; c.price = px; c.qty = qty; c.tif = tf;
    return c;
  endfunction

  // Mostly well-formed traffic on a small key pool so cancels, replaces and a full
  // book all happen; the rest is raw noise across every field bit.
  function automatic order_cmd_t random_cmd();
    order_cmd_t c;
    int unsigned pick;
    c = mk(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), $urandom, $urandom,
           1'($urandom), $urandom, $urandom, 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 9) < 8) begin
      pick = $urandom_range(0, 99);
      c.action = (pick < 55) ? ACT_NEW : (pick < 75) ? ACT_CANCEL : ACT_REPLACE;
      c.instrument = 8'($urandom_range(0, 3));
      c.account = 16'($urandom_range(0, 3));
      c.client_id = $urandom_range(0, 7);
      c.new_client_id = $urandom_range(0, 7);
      c.price = $urandom_range(95, 105);
      c.qty = ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 20);
      pick = $urandom_range(0, 9);
      c.tif = (pick < 6) ? TIF_GTC : (pick < 8) ? TIF_IOC : (pick < 9) ? TIF_FOK : TIF_RSVD;
    end
    return c;
  endfunction

  // Present one command beat; hold it until ready, then record it.
  task automatic send(order_cmd_t c);
    @(negedge clk_i);
    cmd_bus.valid <= 1'b1;
    cmd_bus.action <= c.action;           cmd_bus.instrument <= c.instrument;
    cmd_bus.account <= c.account;         cmd_bus.client_id <= c.client_id;
    cmd_bus.new_client_id <= c.new_client_id; cmd_bus.side <= c.side;
    cmd_bus.limit_price <= c.price;       cmd_bus.order_qty <= c.qty;
    cmd_bus.tif <= c.tif;
    do @(posedge clk_i); while (!cmd_bus.ready);
    sb.note_command(c);
  endtask

  task automatic idle(int unsigned n);
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Send with bursts of back-to-back beats and random gaps between bursts.
  task automatic send_bursty(order_cmd_t c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 1)) idle($urandom_range(0, 8));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send(c);
  endtask

  task automatic drain();
    idle(0);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_enable(logic [3:0] v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.enable = v;
    settings++;
  endtask

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      // Pause midway until the book has answered everything.
      if (i == n / 2) begin
        idle(0);
        while (sb.owed.size() != 0) @(posedge clk_i);
      end
      send_bursty(random_cmd());
    end
  endtask

  initial begin
    cmd_bus.valid = 1'b0;  cmd_bus.action = '0;  cmd_bus.instrument = '0;
    cmd_bus.account = '0;  cmd_bus.client_id = '0;  cmd_bus.new_client_id = '0;
    cmd_bus.side = 1'b0;   cmd_bus.limit_price = '0; cmd_bus.order_qty = '0;
    cmd_bus.tif = '0;      cfg_we = 1'b0;  cfg_wdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Everything disabled: all instruments reject.
    write_enable(4'h0);
    send(mk(ACT_NEW, 8'd0, 16'd1, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd10, TIF_GTC));
    send(mk(ACT_CANCEL, 8'd3, 16'd1, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd10, TIF_GTC));
    drain();

    write_enable(4'hF);
    // Rest, partial fill, FOK short of liquidity, FOK full fill.
    send(mk(ACT_NEW, 8'd0, 16'd1, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd10, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd1, 32'd2, 32'd0, 1'b1, 32'sd101, 32'd5, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd2, 32'd1, 32'd0, 1'b1, 32'sd99, 32'd4, TIF_IOC));
    send(mk(ACT_NEW, 8'd0, 16'd2, 32'd2, 32'd0, 1'b1, 32'sd100, 32'd100, TIF_FOK));
    send(mk(ACT_NEW, 8'd0, 16'd2, 32'd3, 32'd0, 1'b1, 32'sd100, 32'd6, TIF_FOK));
    // Bad price, most negative price, zero quantity, duplicate key.
    send(mk(ACT_NEW, 8'd0, 16'd4, 32'd1, 32'd0, 1'b0, 32'sd0, 32'd1, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd4, 32'd1, 32'd0, 1'b0, 32'h8000_0000, 32'd1, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd4, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd0, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd1, 32'd2, 32'd0, 1'b0, 32'sd50, 32'd1, TIF_GTC));
    // Replaces keeping priority, repriced to trade and rest, bad price, unknown id.
    send(mk(ACT_REPLACE, 8'd0, 16'd1, 32'd2, 32'd7, 1'b0, 32'sd101, 32'd3, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd3, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd2, TIF_GTC));
    send(mk(ACT_REPLACE, 8'd0, 16'd1, 32'd7, 32'd8, 1'b0, 32'sd100, 32'd3, TIF_GTC));
    send(mk(ACT_REPLACE, 8'd0, 16'd1, 32'd8, 32'd9, 1'b0, -32'sd5, 32'd3, TIF_GTC));
    send(mk(ACT_REPLACE, 8'd0, 16'd1, 32'd99, 32'd9, 1'b0, 32'sd100, 32'd3, TIF_GTC));
    // Replace onto a live id of the same account.
    send(mk(ACT_NEW, 8'd0, 16'd1, 32'd9, 32'd0, 1'b0, 32'sd50, 32'd1, TIF_GTC));
    send(mk(ACT_REPLACE, 8'd0, 16'd1, 32'd9, 32'd8, 1'b0, 32'sd50, 32'd1, TIF_GTC));
    // Cancel live, cancel gone, cancel on the wrong instrument.
    send(mk(ACT_CANCEL, 8'd0, 16'd1, 32'd9, 32'd0, 1'b0, 32'sd0, 32'd0, TIF_GTC));
    send(mk(ACT_CANCEL, 8'd0, 16'd1, 32'd9, 32'd0, 1'b0, 32'sd0, 32'd0, TIF_GTC));
    send(mk(ACT_CANCEL, 8'd1, 16'd1, 32'd8, 32'd0, 1'b0, 32'sd0, 32'd0, TIF_GTC));
    // Ignored action, reserved tif at the largest price and quantity.
    send(mk(ACT_NONE, 8'd0, 16'd1, 32'd8, 32'd0, 1'b0, 32'sd100, 32'd1, TIF_GTC));
    send(mk(ACT_NEW, 8'd0, 16'd5, 32'd1, 32'd0, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
            TIF_RSVD));
    // Unknown instruments and full-width ids.
    send(mk(ACT_NEW, 8'd4, 16'd1, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd1, TIF_GTC));
    send(mk(ACT_NEW, 8'd255, 16'd1, 32'd1, 32'd0, 1'b0, 32'sd100, 32'd1, TIF_GTC));
    send(mk(ACT_NEW, 8'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'sd1, 32'd1,
            TIF_GTC));

    // Long receiver hold-off while commands keep coming: the DUT must back up.
    hold_left = LONG_HOLD;
    for (int i = 0; i < 12; i++) send(random_cmd());
    random_phase(90);
    drain();

    write_enable(4'h5);
    random_phase(75);
    drain();

    write_enable(4'hF);
    random_phase(75);
    drain();

    if (sb.owed.size() != 0) sb.errors++;
    $display("ran %0d commands under %0d enable settings, %0d event beats checked",
             sb.commands, settings, sb.checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/potm_pkg.sv
rtl/potm_if.sv
rtl/potm_ctrl.sv
rtl/potm_dp.sv
rtl/price_time_order_matcher_unit.sv
tb/tb.sv
